>>> rtl/vfa_pkg.sv
// shared constants, types and codes for the voxel feature accumulator
package vfa_pkg;

  localparam int GRID_DIM     = 32;
  localparam int NUM_CHANNELS = 18;
  localparam int CELLS        = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int CELL_AW      = $clog2(CELLS);
  localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);

  localparam int ACC_W      = 32;
  localparam int POS_W      = 16;
  localparam int VAL_W      = 16;
  localparam int ADDR_W     = 15;
  localparam int CH_W       = 5;
  localparam int MAXD_W     = 15;
  localparam int INVR_W     = 16;
  localparam int BOX_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // (pos + half extent) is POS_W+1 signed, inv_resolution is INVR_W+1 signed
  localparam int SUM_W  = POS_W + 1;
  localparam int PROD_W = SUM_W + INVR_W + 1;
  localparam int FRAC_W = 16;
  localparam int Q_W    = PROD_W - FRAC_W;
  localparam int CELL_W = Q_W + 1;

  localparam logic [MAXD_W-1:0] MAXD_RST = MAXD_W'(3968);
  localparam logic [INVR_W-1:0] INVR_RST = INVR_W'(256);
  localparam logic [BOX_W-1:0]  BOX_RST  = BOX_W'(32);

  typedef logic [NUM_CHANNELS-1:0][ACC_W-1:0] row_t;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_EXTENT    = 2'd0,
    CFG_INV_RESOLUTION = 2'd1,
    CFG_BOX_CELLS      = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_RMW
  } state_t;

endpackage

>>> rtl/vfa_in_if.sv
// request channel carrying accumulate, read and clear requests
interface vfa_in_if import vfa_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [CH_W-1:0]         feature_channel;
  logic signed [VAL_W-1:0] feature_value;
  logic [ADDR_W-1:0]       cell_address;

  modport source (
    output valid, opcode, pos_x, pos_y, pos_z, feature_channel, feature_value,
           cell_address,
    input  ready
  );
  modport sink (
    input  valid, opcode, pos_x, pos_y, pos_z, feature_channel, feature_value,
           cell_address,
    output ready
  );
endinterface

>>> rtl/vfa_out_if.sv
// result channel carrying one result per request
interface vfa_out_if import vfa_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic                    in_box;
  logic [ADDR_W-1:0]       hit_address;
  logic [CH_W-1:0]         hit_channel;
  logic signed [ACC_W-1:0] cell_sum;
  logic                    saturated;

  modport source (
    output valid, in_box, hit_address, hit_channel, cell_sum, saturated,
    input  ready
  );
  modport sink (
    input  valid, in_box, hit_address, hit_channel, cell_sum, saturated,
    output ready
  );
endinterface

>>> rtl/vfa_cfg_if.sv
// configuration write channel
interface vfa_cfg_if import vfa_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/voxel_feature_accumulator_unit.sv
// voxel feature accumulator: scatter-add of feature values into a voxel grid store
//
// in_chan takes one request at a time: accumulate at a Q8.8 position, read a cell
// or clear a cell, each for one feature channel. out_chan returns exactly one
// result per request, in order. cfg_chan writes the half extent, inv_resolution and
// the box width; it is always ready and is meant to be used while no request is open.
// A request is accepted in the idle state and then passes the multiply state, the
// round and address state, which also issues the row read, and the read-modify-write
// state, which writes back one row of the grid memory (one row per cell holding every
// channel) and registers the result. Only after returning to idle does the block
// accept the next request.
// The result sits in an output register: a new request is accepted while it waits,
// but the next write-back holds until the receiver has taken the previous result.
// After reset a clearing pass zeroes all 32768 rows (GRID_DIM cubed), one row a cycle;
// in_chan is not ready during that pass, cfg_chan still is.
// Dropped requests (outside the box, bad channel, unused opcode)
// return in_box 0 with all other fields 0.
module voxel_feature_accumulator_unit import vfa_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  vfa_in_if.sink    in_chan,
  vfa_out_if.source out_chan,
  vfa_cfg_if.sink   cfg_chan
);

  // configuration
  logic [MAXD_W-1:0] max_dist_r;
  logic [INVR_W-1:0] inv_res_r;
  logic [BOX_W-1:0]  box_cells_r;

  // control
  state_t             state_r, state_nxt;
  logic [CELL_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic               in_ready;
  logic               rd_en;
  logic               wr_en;
  logic               load_out;
  logic               out_free;
  logic               clr_last;

  // request capture
  logic [1:0]              op_r;
  logic [CH_W-1:0]         ch_r;
  logic signed [VAL_W-1:0] val_r;
  logic [ADDR_W-1:0]       caddr_r;
  logic [POS_W-1:0]        pos_r [3];

  // pipeline
  logic signed [SUM_W-1:0]  sum_c  [3];
  logic signed [PROD_W-1:0] prod_c [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic [CELL_W-1:0]        cell_c [3];
  logic [2:0]               inside_c;
  logic                     chan_ok;
  logic                     hit_c;
  logic [CELL_AW-1:0]       addr_c;
  logic                     hit_r;
  logic [CELL_AW-1:0]       addr_r;

  // memory
  row_t               grid_mem [CELLS];
  row_t               rd_row_r;
  row_t               row_mod;
  logic [CELL_AW-1:0] wr_addr;
  row_t               wr_row;

  // read-modify-write
  logic [ACC_W-1:0] old_c;
  logic [ACC_W:0]   ext_c;
  logic             ovf_c;
  logic [ACC_W-1:0] res_sum;
  logic             res_sat;
  logic [ACC_W-1:0] lane_new;

  // output register
  logic              out_valid_r;
  logic              out_in_box_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [ACC_W-1:0]  out_sum_r;
  logic              out_sat_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r  <= MAXD_RST;
      inv_res_r   <= INVR_RST;
      box_cells_r <= BOX_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_HALF_EXTENT:    max_dist_r  <= cfg_chan.data[MAXD_W-1:0];
        CFG_INV_RESOLUTION: inv_res_r   <= cfg_chan.data[INVR_W-1:0];
        CFG_BOX_CELLS:      box_cells_r <= cfg_chan.data[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign clr_last = (clr_cnt_r == CELL_AW'(CELLS - 1));

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_RMW;
      S_RMW: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_CLEAR: wr_en = 1'b1;
      S_IDLE:  in_ready = 1'b1;
      S_ADDR:  rd_en = 1'b1;
      S_RMW: begin
        load_out = out_free;
        wr_en    = out_free && hit_r && (op_r != OP_READ);
      end
      default: ;
    endcase
  end

  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      op_r     <= in_chan.opcode;
      ch_r     <= in_chan.feature_channel;
      val_r    <= in_chan.feature_value;
      caddr_r  <= in_chan.cell_address;
      pos_r[0] <= in_chan.pos_x;
      pos_r[1] <= in_chan.pos_y;
      pos_r[2] <= in_chan.pos_z;
    end
  end

  // shift by the half extent and scale to Q18.16 cell units
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i]  = $signed({pos_r[i][POS_W-1], pos_r[i]}) + $signed({2'b00, max_dist_r});
      prod_c[i] = sum_c[i] * $signed({1'b0, inv_res_r});
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= prod_c[i];
      end
    end
  end

  // floor by arithmetic shift, then round half to even, then box check
  always_comb begin
    logic [Q_W-1:0]    q;
    logic [FRAC_W-1:0] rem;
    logic              up;
    for (int i = 0; i < 3; i++) begin
      q           = prod_r[i][PROD_W-1:FRAC_W];
      rem         = prod_r[i][FRAC_W-1:0];
      up          = rem[FRAC_W-1] && ((rem[FRAC_W-2:0] != '0) || q[0]);
      cell_c[i]   = {q[Q_W-1], q} + CELL_W'(up);
      inside_c[i] = !cell_c[i][CELL_W-1] && (cell_c[i] < CELL_W'(box_cells_r))
                    && (cell_c[i] < CELL_W'(GRID_DIM));
    end
  end

  assign chan_ok = (ch_r < CH_W'(NUM_CHANNELS));

  always_comb begin
    hit_c  = 1'b0;
    addr_c = '0;
    case (op_r)
      OP_ACC: begin
        hit_c  = chan_ok && (&inside_c);
        addr_c = (CELL_AW'(cell_c[0]) * CELL_AW'(GRID_DIM) + CELL_AW'(cell_c[1]))
                 * CELL_AW'(GRID_DIM) + CELL_AW'(cell_c[2]);
      end
      OP_READ, OP_CLEAR: begin
        hit_c  = chan_ok && (32'(caddr_r) < 32'(CELLS));
        addr_c = CELL_AW'(caddr_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ADDR) begin
      hit_r  <= hit_c;
      addr_r <= addr_c;
    end
  end

  // grid memory, one row per cell
  assign wr_addr = (state_r == S_CLEAR) ? clr_cnt_r : addr_r;
  assign wr_row  = (state_r == S_CLEAR) ? '0 : row_mod;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= grid_mem[addr_c];
    end
  end

  // add with saturation, read or clear in the addressed lane
  always_comb begin
    old_c    = rd_row_r[ch_r[CH_IDX_W-1:0]];
    ext_c    = {old_c[ACC_W-1], old_c} + {{(ACC_W+1-VAL_W){val_r[VAL_W-1]}}, val_r};
    ovf_c    = ext_c[ACC_W] ^ ext_c[ACC_W-1];
    res_sum  = '0;
    res_sat  = 1'b0;
    lane_new = old_c;
    case (op_r)
      OP_ACC: begin
        res_sat = ovf_c;
        if (ovf_c) begin
          res_sum = ext_c[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          res_sum = ext_c[ACC_W-1:0];
        end
        lane_new = res_sum;
      end
      OP_READ:  res_sum = old_c;
      OP_CLEAR: lane_new = '0;
      default: ;
    endcase
    if (!hit_r) begin
      res_sum = '0;
      res_sat = 1'b0;
    end
    row_mod = rd_row_r;
    row_mod[ch_r[CH_IDX_W-1:0]] = lane_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_in_box_r <= hit_r;
      out_addr_r   <= hit_r ? ADDR_W'(addr_r) : '0;
      out_ch_r     <= hit_r ? ch_r : '0;
      out_sum_r    <= res_sum;
      out_sat_r    <= res_sat;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.in_box      = out_in_box_r;
  assign out_chan.hit_address = out_addr_r;
  assign out_chan.hit_channel = out_ch_r;
  assign out_chan.cell_sum    = out_sum_r;
  assign out_chan.saturated   = out_sat_r;

  a_wr_state : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CLEAR || state_r == S_RMW))
    else $error("grid memory written outside clearing pass or write-back");

  a_out_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RMW))
    else $error("result raised without a write-back step");

  a_drop_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_in_box_r) |->
      (out_sum_r == '0 && !out_sat_r && out_addr_r == '0 && out_ch_r == '0))
    else $error("dropped request carries a non-zero payload");

  a_accept_mul : assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == S_MUL))
    else $error("accepted request did not enter the multiply step");

endmodule

>>> bench/tb.sv
// self-checking bench for the voxel feature accumulator unit
`timescale 1ns / 1ps

module tb;
  import vfa_pkg::*;

  localparam logic [1:0]           OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int CELL_MID     = 16 * 1024 + 16 * 32 + 16;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [CH_W-1:0]         ch;
    logic signed [VAL_W-1:0] value;
    logic [ADDR_W-1:0]       addr;
  } voxel_req_t;

  typedef struct packed {
    logic                    in_box;
    logic [ADDR_W-1:0]       hit_address;
    logic [CH_W-1:0]         hit_channel;
    logic signed [ACC_W-1:0] cell_sum;
    logic                    saturated;
  } voxel_hit_t;

  // grid accumulator mirror with the queue of hits it expects back
  class grid_scoreboard;
    logic [MAXD_W-1:0] maxd;
    logic [INVR_W-1:0] invr;
    logic [BOX_W-1:0]  box;
    int                acc_store[int];
    voxel_hit_t        expected_hits[$];
    int n_errors, n_reqs, n_in_box, n_dropped, n_sat, n_writes;

    function new();
      maxd = MAXD_RST;
      invr = INVR_RST;
      box  = BOX_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      case (idx)
        CFG_HALF_EXTENT:    maxd = data[MAXD_W-1:0];
        CFG_INV_RESOLUTION: invr = data[INVR_W-1:0];
        CFG_BOX_CELLS:      box  = data[BOX_W-1:0];
        default: ;
      endcase
    endfunction

    // floor of (pos + maxd) * invr / 2^16, then round half to even
    function longint cell_coord(logic signed [POS_W-1:0] p);
      longint prod, q, rem;
      prod = (longint'(p) + longint'(maxd)) * longint'(invr);
      q    = prod >>> 16;
      rem  = prod - (q <<< 16);
      if (rem > 32768 || (rem == 32768 && (q & 1) != 0)) q++;
      return q;
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction

    function void note_request(voxel_req_t r);
      voxel_hit_t h;
      longint cx, cy, cz, lim, s;
      int addr, key;
      h = '0;
      n_reqs++;
      if (r.op == OP_UNUSED || r.ch >= NUM_CHANNELS) begin
        n_dropped++;
        expected_hits = {expected_hits, h};
        return;
      end
      if (r.op == OP_ACC) begin
        lim = (box < GRID_DIM) ? longint'(box) : longint'(GRID_DIM);
        cx = cell_coord(r.pos_x);
        cy = cell_coord(r.pos_y);
        cz = cell_coord(r.pos_z);
        if (cx < 0 || cx >= lim || cy < 0 || cy >= lim || cz < 0 || cz >= lim) begin
          n_dropped++;
          expected_hits = {expected_hits, h};
          return;
        end
        addr = int'((cx * GRID_DIM + cy) * GRID_DIM + cz);
        key  = addr * NUM_CHANNELS + int'(r.ch);
        s = (acc_store.exists(key) ? longint'(acc_store[key]) : 0) + longint'(r.value);
        if (s > 64'sd2147483647) begin
          s = 64'sd2147483647;
          h.saturated = 1'b1;
        end
        if (s < -64'sd2147483648) begin
          s = -64'sd2147483648;
          h.saturated = 1'b1;
        end
        if (h.saturated) n_sat++;
        acc_store[key] = int'(s);
      end else begin
        addr = int'(r.addr);
        key  = addr * NUM_CHANNELS + int'(r.ch);
        if (r.op == OP_CLEAR) acc_store[key] = 0;
        s = acc_store.exists(key) ? longint'(acc_store[key]) : 0;
      end
      n_in_box++;
      h.in_box      = 1'b1;
      h.hit_address = ADDR_W'(addr);
      h.hit_channel = r.ch;
      h.cell_sum    = ACC_W'(s);
      expected_hits = {expected_hits, h};
    endfunction

    task report(string what, longint e, longint g);
      n_errors++;
      $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, e, g);
    endtask

    task check_result(voxel_hit_t got);
      voxel_hit_t e;
      if (expected_hits.size() == 0) begin
        report("result with nothing outstanding, cell_sum", 0, longint'(got.cell_sum));
        return;
      end
      e = expected_hits.pop_front();
      if (got.in_box !== e.in_box) report("in_box", e.in_box, got.in_box);
      if (got.hit_address !== e.hit_address)
        report("hit_address", e.hit_address, got.hit_address);
      if (got.hit_channel !== e.hit_channel)
        report("hit_channel", e.hit_channel, got.hit_channel);
      if (got.cell_sum !== e.cell_sum) report("cell_sum", e.cell_sum, got.cell_sum);
      if (got.saturated !== e.saturated) report("saturated", e.saturated, got.saturated);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle, recv_idle, n_settings;
  grid_scoreboard sb;
  int   touched_addr[$];
  int   touched_ch[$];

  vfa_in_if  in_chan ();
  vfa_out_if out_chan ();
  vfa_cfg_if cfg_chan ();

  voxel_feature_accumulator_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (cfg_chan.valid && cfg_chan.ready) sb.write_reg(cfg_chan.index, cfg_chan.data);
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request({in_chan.opcode, in_chan.pos_x, in_chan.pos_y, in_chan.pos_z,
                         in_chan.feature_channel, in_chan.feature_value,
                         in_chan.cell_address});
      end
      if (out_chan.valid && out_chan.ready) begin
        sb.check_result({out_chan.in_box, out_chan.hit_address, out_chan.hit_channel,
                         out_chan.cell_sum, out_chan.saturated});
      end
    end
  end

  function automatic voxel_req_t mk(logic [1:0] op, int x, int y, int z, int ch, int v,
                                    int addr);
    voxel_req_t r;
    r.op    = op;
    r.pos_x = POS_W'(x);
    r.pos_y = POS_W'(y);
    r.pos_z = POS_W'(z);
    r.ch    = CH_W'(ch);
    r.value = VAL_W'(v);
    r.addr  = ADDR_W'(addr);
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic apply_setting(int m, int i, int b);
    n_settings++;
    write_reg(CFG_HALF_EXTENT, CFG_DATA_W'(m));
    write_reg(CFG_INV_RESOLUTION, CFG_DATA_W'(i));
    write_reg(CFG_BOX_CELLS, CFG_DATA_W'(b));
  endtask

  task automatic send_req(voxel_req_t r);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid           <= 1'b1;
    in_chan.opcode          <= r.op;
    in_chan.pos_x           <= r.pos_x;
    in_chan.pos_y           <= r.pos_y;
    in_chan.pos_z           <= r.pos_z;
    in_chan.feature_channel <= r.ch;
    in_chan.feature_value   <= r.value;
    in_chan.cell_address    <= r.addr;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // lower valid and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // position aimed at cell t with a small jitter, sometimes at the rounding tie above it
  function automatic logic signed [POS_W-1:0] aim_axis(int t);
    longint p;
    int j;
    j = $urandom_range(4);
    p = longint'(t) * 65536 + (($urandom_range(3) == 0) ? 32768 : 0);
    p = p / longint'(sb.invr) - longint'(sb.maxd) + j - 2;
    if (p < -32768 || p > 32767) return POS_W'($urandom);
    return POS_W'(p);
  endfunction

  function automatic voxel_req_t make_request();
    voxel_req_t r;
    int roll, lim, tx, ty, tz, k;
    roll = $urandom_range(99);
    lim  = (sb.box < GRID_DIM) ? int'(sb.box) : GRID_DIM;
    r = mk(OP_ACC, $urandom, $urandom, $urandom, $urandom_range(NUM_CHANNELS - 1),
           $urandom, $urandom);
    if (roll < 62) begin
      if (roll < 52 && lim > 0 && sb.invr != 0) begin
        tx = $urandom_range(lim - 1);
        ty = $urandom_range(lim - 1);
        tz = $urandom_range(lim - 1);
        r.pos_x = aim_axis(tx);
        r.pos_y = aim_axis(ty);
        r.pos_z = aim_axis(tz);
        // now and then knock one axis off target
        if (roll < 6) r.pos_y = POS_W'($urandom);
        touched_addr = {touched_addr, tx * 1024 + ty * 32 + tz};
        touched_ch   = {touched_ch, int'(r.ch)};
        if (touched_addr.size() > 64) begin
          void'(touched_addr.pop_front());
          void'(touched_ch.pop_front());
        end
      end
    end else if (roll < 90) begin
      r.op = (roll < 80) ? OP_READ : OP_CLEAR;
      if (touched_addr.size() > 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(touched_addr.size() - 1);
        r.addr = ADDR_W'(touched_addr[k]);
        r.ch   = CH_W'(touched_ch[k]);
      end
    end else if (roll < 95) begin
      r.op = 2'($urandom_range(3));
      r.ch = CH_W'($urandom_range(31, NUM_CHANNELS));
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic run_phase(int n, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      send_req(make_request());
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    voxel_req_t directed[$];
    sb = new();
    send_idle = 30;
    recv_idle = 82;
    n_settings = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = OP_ACC;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.pos_z = '0;
    in_chan.feature_channel = '0;
    in_chan.feature_value = '0;
    in_chan.cell_address = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_HALF_EXTENT;
    cfg_chan.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // a write to the spare index must change nothing
    write_reg(CFG_SPARE, 16'hFFFF);

    // reset settings: ties, box edges, bad channels, unused opcode, read and clear
    directed = {directed, mk(OP_ACC, 0, 0, 0, 0, 256, 0)};
    directed = {directed, mk(OP_ACC, -3968, -3968, -3968, 17, 32767, 32767)};
    directed = {directed, mk(OP_ACC, 32767, 32767, 32767, 3, 100, 0)};
    directed = {directed, mk(OP_ACC, -32768, -32768, -32768, 3, -1, 0)};
    directed = {directed, mk(OP_ACC, -3968 + 128, -3968 + 384, -3968 - 128, 2, -32768, 0)};
    directed = {directed, mk(OP_ACC, -3968 - 129, 0, 0, 2, 5, 0)};
    directed = {directed, mk(OP_ACC, 4096, 0, 0, 1, 7, 0)};
    directed = {directed, mk(OP_ACC, 4095, 4095, 4095, 1, -7, 0)};
    directed = {directed, mk(OP_ACC, -3968 + 127, -3968 + 129, 0, 4, 9, 0)};
    directed = {directed, mk(OP_ACC, 0, 0, 0, 18, 1, 0)};
    directed = {directed, mk(OP_ACC, 0, 0, 0, 31, 1, 0)};
    directed = {directed, mk(OP_UNUSED, 0, 0, 0, 0, 1, CELL_MID)};
    directed = {directed, mk(OP_READ, 0, 0, 0, 0, 0, CELL_MID)};
    directed = {directed, mk(OP_READ, -1, -1, -1, 17, -1, 0)};
    directed = {directed, mk(OP_READ, 0, 0, 0, 1, 0, 32767)};
    directed = {directed, mk(OP_READ, 0, 0, 0, 31, 0, 32767)};
    directed = {directed, mk(OP_CLEAR, 0, 0, 0, 17, 0, 0)};
    directed = {directed, mk(OP_READ, 0, 0, 0, 17, 0, 0)};
    directed = {directed, mk(OP_ACC, -3968, -3968, -3968, 17, -32768, 0)};
    directed = {directed, mk(OP_READ, 0, 0, 0, 2, 0, 64)};
    directed = {directed, mk(OP_CLEAR, 0, 0, 0, 18, 0, 64)};
    directed = {directed, mk(OP_READ, 0, 0, 0, 2, 0, 64)};
    directed = {directed, mk(OP_CLEAR, 0, 0, 0, 2, 0, 64)};
    directed = {directed, mk(OP_READ, 0, 0, 0, 2, 0, 64)};
    directed = {directed, mk(OP_READ, 0, 0, 0, 4, 0, 48)};
    foreach (directed[i]) send_req(directed[i]);
    drain();

    apply_setting(3968, 256, 32);
    run_phase(200, 30, 82);
    apply_setting(1, 65535, 1);
    run_phase(200, 30, 82);
    apply_setting($urandom_range(8192, 256), $urandom_range(1024, 64), $urandom_range(32, 1));
    run_phase(200, 82, 30);
    apply_setting(32767, 1, 63);
    run_phase(200, 82, 30);
    apply_setting(3968, 256, 0);
    run_phase(100, 0, 0);
    apply_setting($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    run_phase(150, 0, 0);
    apply_setting(2048, 512, 17);
    run_phase(200, 0, 0);
    repeat (16) @(posedge clk);

    $display("run covered %0d requests over %0d register settings and %0d writes",
             sb.n_reqs, n_settings, sb.n_writes);
    $display("%0d in box or read/clear, %0d dropped, %0d clipped adds",
             sb.n_in_box, sb.n_dropped, sb.n_sat);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(64'd40_000_000);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("tb failed");
    $finish;
  end

endmodule
